// File: hw/rtl/tdrs_pkg.sv
// shared types and constants of the transmit descriptor ring splitter
package tdrs_pkg;

   localparam int ADDR_W      = 48;
   localparam int LEN_W       = 14;
   localparam int BYTES_W     = 13;
   localparam int ID_W        = 16;
   localparam int COUNT_W     = 16;
   localparam int DONE_W      = 13;
   localparam int SLOT_W      = 12;
   localparam int THRESH_W    = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int MAX_PIECES  = 5;
   localparam int PIECE_CNT_W = 3;

   localparam logic [BYTES_W-1:0] BYTES_MAX = 13'h1fff;

   typedef enum logic {
      CMD_SEGMENT    = 1'b0,
      CMD_COMPLETION = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_DESC     = 2'd0,
      KIND_DOORBELL = 2'd1,
      KIND_REJECT   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHYS_MODE      = 1'b0,
      CSR_PUSH_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_DOORBELL
   } state_type;

   typedef struct packed {
      command_type         command;
      logic [ADDR_W-1:0]   seg_address;
      logic [LEN_W-1:0]    seg_length;
      logic                last_segment;
      logic [ID_W-1:0]     request_id;
      logic [DONE_W-1:0]   done_count;
   } req_payload_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   ring_slot;
      logic [ADDR_W-1:0]   desc_address;
      logic [BYTES_W-1:0]  desc_bytes;
      logic                continued;
      logic [ID_W-1:0]     out_request_id;
      logic                id_valid;
      logic                push_descriptor;
      logic                last;
   } rsp_payload_type;

   // operands handed from the sequencer to the chunk unit
   typedef struct packed {
      logic                   phys_mode;
      logic [ADDR_W-1:0]      addr;
      logic [LEN_W-1:0]       len;
      logic                   last_seg;
      logic [PIECE_CNT_W-1:0] piece_cnt;
      logic [COUNT_W-1:0]     write_count;
      logic [COUNT_W-1:0]     done_ptr;
   } chunk_operand_type;

   // one step of the split, as computed by the chunk unit
   typedef struct packed {
      logic                ring_full;
      logic [BYTES_W-1:0]  bytes;
      logic                final_piece;
      logic                cont;
      logic                id_valid;
      logic [ADDR_W-1:0]   next_addr;
      logic [LEN_W-1:0]    next_len;
      logic [SLOT_W-1:0]   slot;
   } chunk_result_type;

endpackage

// File: hw/rtl/tdrs_chunk_unit.sv
// shared chunk unit: page split, ring full check and pointer arithmetic for one descriptor
module tdrs_chunk_unit #(
   parameter int RING_ENTRIES = 512,
   parameter int PAGE_BYTES   = 4096
) (
   input  tdrs_pkg::chunk_operand_type op,
   output tdrs_pkg::chunk_result_type  res
);

   localparam int PAGE_BITS = $clog2(PAGE_BYTES);
   localparam int SLOT_BITS = $clog2(RING_ENTRIES);
   localparam int CMP_W     = (PAGE_BITS + 1 > tdrs_pkg::LEN_W) ?
                              PAGE_BITS + 1 : tdrs_pkg::LEN_W;

   logic [CMP_W-1:0]                to_edge;
   logic [CMP_W-1:0]                len_ext;
   logic                            take_all;
   logic [tdrs_pkg::LEN_W-1:0]      piece;
   logic [tdrs_pkg::COUNT_W-1:0]    occupancy;

   // bytes up to the next page edge
   assign to_edge  = CMP_W'(PAGE_BYTES) - CMP_W'(op.addr[PAGE_BITS-1:0]);
   assign len_ext  = CMP_W'(op.len);
   assign take_all = op.phys_mode || (to_edge > len_ext) ||
                     (op.piece_cnt == tdrs_pkg::PIECE_CNT_W'(tdrs_pkg::MAX_PIECES - 1));
   assign piece    = take_all ? op.len : tdrs_pkg::LEN_W'(to_edge);

   // ring occupancy against the full mark
   assign occupancy = op.write_count - op.done_ptr;

   always_comb begin
      res.ring_full   = occupancy >= tdrs_pkg::COUNT_W'(RING_ENTRIES - 1);
      res.bytes       = (piece > tdrs_pkg::LEN_W'(tdrs_pkg::BYTES_MAX)) ?
                        tdrs_pkg::BYTES_MAX : piece[tdrs_pkg::BYTES_W-1:0];
      res.final_piece = (piece == op.len);
      res.id_valid    = op.last_seg && (piece == op.len);
      res.cont        = op.phys_mode ? !op.last_seg : !(op.last_seg && (piece == op.len));
      res.next_addr   = op.addr + tdrs_pkg::ADDR_W'(piece);
      res.next_len    = op.len - piece;
      res.slot        = tdrs_pkg::SLOT_W'(op.write_count[SLOT_BITS-1:0]);
   end

endmodule

// File: hw/rtl/tdrs_seq.sv
// sequencer: ring pointers, configuration, split state machine and result register
module tdrs_seq #(
   parameter int RING_ENTRIES = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tdrs_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tdrs_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tdrs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tdrs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tdrs_pkg::chunk_operand_type          op,
   input  tdrs_pkg::chunk_result_type           res
);

   localparam int SLOT_BITS = $clog2(RING_ENTRIES);

   tdrs_pkg::state_type                  state_ff, state_in;
   logic                                 phys_mode_ff, phys_mode_in;
   logic [tdrs_pkg::THRESH_W-1:0]        push_threshold_ff, push_threshold_in;
   logic [tdrs_pkg::COUNT_W-1:0]         write_count_ff, write_count_in;
   logic [tdrs_pkg::COUNT_W-1:0]         done_ptr_ff, done_ptr_in;
   logic [tdrs_pkg::COUNT_W-1:0]         doorbell_ptr_ff, doorbell_ptr_in;
   logic [tdrs_pkg::COUNT_W-1:0]         packet_start_ff, packet_start_in;
   logic                                 in_packet_ff, in_packet_in;
   logic                                 dropping_ff, dropping_in;
   logic [tdrs_pkg::ADDR_W-1:0]          addr_ff, addr_in;
   logic [tdrs_pkg::LEN_W-1:0]           len_ff, len_in;
   logic                                 last_seg_ff, last_seg_in;
   logic [tdrs_pkg::ID_W-1:0]            rid_ff, rid_in;
   logic [tdrs_pkg::PIECE_CNT_W-1:0]     piece_cnt_ff, piece_cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   tdrs_pkg::rsp_payload_type            rsp_data_ff, rsp_data_in;

   logic                                 req_accept;
   logic                                 is_segment;
   logic                                 slot_free;
   logic [tdrs_pkg::COUNT_W-1:0]         room;
   logic [tdrs_pkg::COUNT_W-1:0]         done_req;
   logic [tdrs_pkg::COUNT_W-1:0]         done_eff;
   logic [tdrs_pkg::COUNT_W-1:0]         occupancy;
   logic                                 single_desc;
   logic                                 push;

   // handshake
   assign req_stall   = (state_ff != tdrs_pkg::ST_IDLE);
   assign req_accept  = req_valid && (state_ff == tdrs_pkg::ST_IDLE);
   assign is_segment  = (req_payload.command == tdrs_pkg::CMD_SEGMENT);
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign csr_ready   = 1'b1;

   // completion clamp: never past the published pointer
   assign room     = doorbell_ptr_ff - done_ptr_ff;
   assign done_req = tdrs_pkg::COUNT_W'(req_payload.done_count);
   assign done_eff = (done_req > room) ? room : done_req;

   // doorbell push decision
   assign occupancy   = doorbell_ptr_ff - done_ptr_ff;
   assign single_desc = ((write_count_ff - doorbell_ptr_ff) == tdrs_pkg::COUNT_W'(1));
   assign push        = (occupancy < tdrs_pkg::COUNT_W'(push_threshold_ff)) && single_desc;

   // operands for the chunk unit
   always_comb begin
      op.phys_mode   = phys_mode_ff;
      op.addr        = addr_ff;
      op.len         = len_ff;
      op.last_seg    = last_seg_ff;
      op.piece_cnt   = piece_cnt_ff;
      op.write_count = write_count_ff;
      op.done_ptr    = done_ptr_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdrs_pkg::ST_IDLE: begin
            if (req_accept && is_segment && !dropping_ff) begin
               state_in = tdrs_pkg::ST_SPLIT;
            end
         end
         tdrs_pkg::ST_SPLIT: begin
            if (slot_free) begin
               if (res.ring_full) begin
                  state_in = tdrs_pkg::ST_IDLE;
               end else if (res.final_piece) begin
                  state_in = last_seg_ff ? tdrs_pkg::ST_DOORBELL : tdrs_pkg::ST_IDLE;
               end
            end
         end
         tdrs_pkg::ST_DOORBELL: begin
            if (slot_free) begin
               state_in = tdrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdrs_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and result register updates
   always_comb begin
      phys_mode_in      = phys_mode_ff;
      push_threshold_in = push_threshold_ff;
      write_count_in    = write_count_ff;
      done_ptr_in       = done_ptr_ff;
      doorbell_ptr_in   = doorbell_ptr_ff;
      packet_start_in   = packet_start_ff;
      in_packet_in      = in_packet_ff;
      dropping_in       = dropping_ff;
      addr_in           = addr_ff;
      len_in            = len_ff;
      last_seg_in       = last_seg_ff;
      rid_in            = rid_ff;
      piece_cnt_in      = piece_cnt_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_data_in       = rsp_data_ff;

      // configuration writes
      if (csr_valid) begin
         unique case (tdrs_pkg::csr_index_type'(csr_index))
            tdrs_pkg::CSR_PHYS_MODE:      phys_mode_in      = csr_wdata[0];
            tdrs_pkg::CSR_PUSH_THRESHOLD: push_threshold_in = csr_wdata;
            default:                      phys_mode_in      = phys_mode_ff;
         endcase
      end

      unique case (state_ff)
         tdrs_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (!is_segment) begin
                  done_ptr_in = done_ptr_ff + done_eff;
               end else if (dropping_ff) begin
                  if (req_payload.last_segment) begin
                     dropping_in = 1'b0;
                  end
               end else begin
                  if (!in_packet_ff) begin
                     packet_start_in = write_count_ff;
                     in_packet_in    = 1'b1;
                  end
                  addr_in      = req_payload.seg_address;
                  len_in       = req_payload.seg_length;
                  last_seg_in  = req_payload.last_segment;
                  rid_in       = req_payload.request_id;
                  piece_cnt_in = '0;
               end
            end
         end
         tdrs_pkg::ST_SPLIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (res.ring_full) begin
                  // rewind to packet start and drop the rest of the packet
                  write_count_in        = packet_start_ff;
                  in_packet_in          = 1'b0;
                  dropping_in           = !last_seg_ff;
                  rsp_data_in.kind      = tdrs_pkg::KIND_REJECT;
                  rsp_data_in.ring_slot =
                     tdrs_pkg::SLOT_W'(packet_start_ff[SLOT_BITS-1:0]);
                  rsp_data_in.last      = 1'b1;
               end else begin
                  rsp_data_in.kind           = tdrs_pkg::KIND_DESC;
                  rsp_data_in.ring_slot      = res.slot;
                  rsp_data_in.desc_address   = addr_ff;
                  rsp_data_in.desc_bytes     = res.bytes;
                  rsp_data_in.continued      = res.cont;
                  rsp_data_in.id_valid       = res.id_valid;
                  rsp_data_in.out_request_id = res.id_valid ? rid_ff : '0;
                  rsp_data_in.last           = res.final_piece && !last_seg_ff;
                  write_count_in             = write_count_ff + tdrs_pkg::COUNT_W'(1);
                  addr_in                    = res.next_addr;
                  len_in                     = res.next_len;
                  piece_cnt_in               = piece_cnt_ff + tdrs_pkg::PIECE_CNT_W'(1);
               end
            end
         end
         tdrs_pkg::ST_DOORBELL: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.kind            = tdrs_pkg::KIND_DOORBELL;
               rsp_data_in.ring_slot       =
                  tdrs_pkg::SLOT_W'(write_count_ff[SLOT_BITS-1:0]);
               rsp_data_in.push_descriptor = push;
               rsp_data_in.last            = 1'b1;
               doorbell_ptr_in             = write_count_ff;
               in_packet_in                = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= tdrs_pkg::ST_IDLE;
         phys_mode_ff      <= 1'b0;
         push_threshold_ff <= '0;
         write_count_ff    <= '0;
         done_ptr_ff       <= '0;
         doorbell_ptr_ff   <= '0;
         packet_start_ff   <= '0;
         in_packet_ff      <= 1'b0;
         dropping_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         phys_mode_ff      <= phys_mode_in;
         push_threshold_ff <= push_threshold_in;
         write_count_ff    <= write_count_in;
         done_ptr_ff       <= done_ptr_in;
         doorbell_ptr_ff   <= doorbell_ptr_in;
         packet_start_ff   <= packet_start_in;
         in_packet_ff      <= in_packet_in;
         dropping_ff       <= dropping_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      last_seg_ff  <= last_seg_in;
      rid_ff       <= rid_in;
      piece_cnt_ff <= piece_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// File: hw/rtl/tx_descriptor_ring_splitter_core.sv
// top level of the transmit descriptor ring splitter
// a segment request is accepted only in idle and then gives one descriptor per cycle
// (1 to 5, set by page crossings; 1 in physical mode) while rsp_stall is low, and one doorbell
// on a packet's last segment; a full ring ends the request with a reject instead
// completion and dropped requests give no result
// reset (synchronous) clears ring pointers, packet state and both csr registers
module tx_descriptor_ring_splitter_core #(
   parameter int RING_ENTRIES = 512,
   parameter int PAGE_BYTES   = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tdrs_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tdrs_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdrs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tdrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tdrs_pkg::chunk_operand_type op;
   tdrs_pkg::chunk_result_type  res;

   // sequencer with ring state and result register
   tdrs_seq #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .op          (op),
      .res         (res)
   );

   // shared split and pointer arithmetic
   tdrs_chunk_unit #(
      .RING_ENTRIES (RING_ENTRIES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_chunk (
      .op  (op),
      .res (res)
   );

endmodule

// File: hw/rtl/tdrs_checker.sv
// port-level checks for the transmit descriptor ring splitter
module tdrs_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  tdrs_pkg::rsp_payload_type         rsp_payload
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // the descriptor carrying the request id closes the packet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.id_valid |->
         !rsp_payload.continued && (rsp_payload.kind == tdrs_pkg::KIND_DESC))
      else $error("request id on a continued or non-descriptor result");

   // doorbell and reject always end the request's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_payload.kind == tdrs_pkg::KIND_DOORBELL) ||
                    (rsp_payload.kind == tdrs_pkg::KIND_REJECT)) |-> rsp_payload.last)
      else $error("doorbell or reject without last");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tx_descriptor_ring_splitter_core tdrs_checker u_tdrs_checker (.*);

// File: test/tb_tx_descriptor_ring_splitter_core.sv
`timescale 1ns / 1ps
// testbench for the transmit descriptor ring splitter: directed and random requests checked
module tb_tx_descriptor_ring_splitter_core;

   localparam int RING_ENTRIES   = 512;
   localparam int PAGE_BYTES     = 4096;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 20;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   tdrs_pkg::req_payload_type        req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   tdrs_pkg::rsp_payload_type        rsp_payload;
   logic                             csr_valid   = 1'b0;
   logic                             csr_ready;
   logic [tdrs_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [tdrs_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   // predicted ring state and registers
   logic [tdrs_pkg::COUNT_W-1:0]  wr_cnt     = '0;
   logic [tdrs_pkg::COUNT_W-1:0]  rm_ptr     = '0;
   logic [tdrs_pkg::COUNT_W-1:0]  db_ptr     = '0;
   logic [tdrs_pkg::COUNT_W-1:0]  pkt_start  = '0;
   logic                          in_pkt     = 1'b0;
   logic                          drop_rest  = 1'b0;
   logic                          cfg_phys   = 1'b0;
   logic [tdrs_pkg::THRESH_W-1:0] cfg_thresh = '0;

   tdrs_pkg::req_payload_type segment_backlog[$];
   tdrs_pkg::rsp_payload_type due_results[$];
   tdrs_pkg::rsp_payload_type oldest_due;

   // stimulus shaping and bookkeeping
   bit hold_req   = 1'b0;
   bit hold_taken = 1'b0;
   bit calm       = 1'b0;
   int hold_left  = 0;
   int stall_left = 0;
   int gap_left   = 0;
   int quiet_cycles = 0;
   int error_count    = 0;
   int requests_sent  = 0;
   int results_seen   = 0;
   int rejects_seen   = 0;
   int doorbells_seen = 0;
   int pushes_seen    = 0;

   tx_descriptor_ring_splitter_core #(
      .RING_ENTRIES (RING_ENTRIES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [tdrs_pkg::SLOT_W-1:0] slot_of(
      input logic [tdrs_pkg::COUNT_W-1:0] cnt);
      return tdrs_pkg::SLOT_W'(cnt & tdrs_pkg::COUNT_W'(RING_ENTRIES - 1));
   endfunction

   // expected ring writes, doorbells and rejects for one accepted request
   function automatic void ring_producer_step(input tdrs_pkg::req_payload_type rq);
      tdrs_pkg::rsp_payload_type    outs [7];
      logic [tdrs_pkg::ADDR_W-1:0]  addr;
      logic [tdrs_pkg::COUNT_W-1:0] occ;
      logic [tdrs_pkg::COUNT_W-1:0] span;
      int                           len;
      int                           piece;
      int                           to_edge;
      int                           n;
      logic                         fin;
      logic                         ends;
      logic                         rejected;
      addr     = rq.seg_address;
      len      = int'(rq.seg_length);
      n        = 0;
      rejected = 1'b0;
      // completion retires descriptors, never past the doorbell
      if (rq.command == tdrs_pkg::CMD_COMPLETION) begin
         occ = db_ptr - rm_ptr;
         if (tdrs_pkg::COUNT_W'(rq.done_count) > occ) rm_ptr = rm_ptr + occ;
         else rm_ptr = rm_ptr + tdrs_pkg::COUNT_W'(rq.done_count);
         return;
      end
      // rest of a rejected packet is swallowed
      if (drop_rest) begin
         if (rq.last_segment) drop_rest = 1'b0;
         return;
      end
      if (!in_pkt) begin
         pkt_start = wr_cnt;
         in_pkt    = 1'b1;
      end
      // one descriptor per chunk, room checked before each
      do begin
         occ = wr_cnt - rm_ptr;
         if (int'(occ) >= RING_ENTRIES - 1) begin
            outs[n]           = '0;
            outs[n].kind      = tdrs_pkg::KIND_REJECT;
            outs[n].ring_slot = slot_of(pkt_start);
            n++;
            wr_cnt    = pkt_start;
            in_pkt    = 1'b0;
            drop_rest = !rq.last_segment;
            rejected  = 1'b1;
         end else begin
            if (cfg_phys) begin
               piece = len;
            end else begin
               to_edge = PAGE_BYTES - int'(addr % tdrs_pkg::ADDR_W'(PAGE_BYTES));
               piece   = (to_edge > len || n == tdrs_pkg::MAX_PIECES - 1) ? len : to_edge;
            end
            fin  = (piece == len);
            ends = rq.last_segment && fin;
            outs[n]                = '0;
            outs[n].kind           = tdrs_pkg::KIND_DESC;
            outs[n].ring_slot      = slot_of(wr_cnt);
            outs[n].desc_address   = addr;
            outs[n].desc_bytes     = (piece > int'(tdrs_pkg::BYTES_MAX)) ?
                                     tdrs_pkg::BYTES_MAX : tdrs_pkg::BYTES_W'(piece);
            outs[n].continued      = cfg_phys ? !rq.last_segment : !ends;
            outs[n].id_valid       = ends;
            outs[n].out_request_id = ends ? rq.request_id : '0;
            n++;
            wr_cnt = wr_cnt + tdrs_pkg::COUNT_W'(1);
            addr   = addr + tdrs_pkg::ADDR_W'(piece);
            len    = len - piece;
         end
      end while (len > 0 && !rejected);
      // doorbell once the packet's last segment is in
      if (!rejected && rq.last_segment) begin
         occ  = db_ptr - rm_ptr;
         span = wr_cnt - db_ptr;
         outs[n]                 = '0;
         outs[n].kind            = tdrs_pkg::KIND_DOORBELL;
         outs[n].ring_slot       = slot_of(wr_cnt);
         outs[n].push_descriptor = (occ < tdrs_pkg::COUNT_W'(cfg_thresh)) &&
                                   (span == tdrs_pkg::COUNT_W'(1));
         n++;
         db_ptr = wr_cnt;
         in_pkt = 1'b0;
      end
      outs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   function automatic tdrs_pkg::req_payload_type segment_req(
      input logic [tdrs_pkg::ADDR_W-1:0] addr,
      input logic [tdrs_pkg::LEN_W-1:0]  len,
      input logic                        last,
      input logic [tdrs_pkg::ID_W-1:0]   rid);
      tdrs_pkg::req_payload_type p;
      p.command      = tdrs_pkg::CMD_SEGMENT;
      p.seg_address  = addr;
      p.seg_length   = len;
      p.last_segment = last;
      p.request_id   = rid;
      p.done_count   = tdrs_pkg::DONE_W'($urandom);
      return p;
   endfunction

   function automatic tdrs_pkg::req_payload_type completion_req(
      input logic [tdrs_pkg::DONE_W-1:0] cnt);
      tdrs_pkg::req_payload_type p;
      p.command      = tdrs_pkg::CMD_COMPLETION;
      p.seg_address  = {16'($urandom), $urandom};
      p.seg_length   = tdrs_pkg::LEN_W'($urandom);
      p.last_segment = 1'($urandom);
      p.request_id   = tdrs_pkg::ID_W'($urandom);
      p.done_count   = cnt;
      return p;
   endfunction

   // random address, often close to a page edge or the top of the space
   function automatic logic [tdrs_pkg::ADDR_W-1:0] pick_address();
      logic [tdrs_pkg::ADDR_W-1:0] a;
      a = {16'($urandom), $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: a[11:0] = 12'hfff - 12'($urandom_range(0, 40));
         2: a[tdrs_pkg::ADDR_W-1:16] = '1;
         default: a[11:0] = '0;
      endcase
      return a;
   endfunction

   // random packets of 1 to 3 segments, mixed with completions
   task automatic queue_packets(input int count, input int done_pct, input bit long_segs);
      int                         queued;
      int                         nseg;
      logic [tdrs_pkg::LEN_W-1:0] len;
      logic                       last;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(1, 100) <= done_pct) begin
            if ($urandom_range(0, 3) == 0)
               segment_backlog.push_back(
                  completion_req(tdrs_pkg::DONE_W'($urandom_range(0, 4096))));
            else
               segment_backlog.push_back(
                  completion_req(tdrs_pkg::DONE_W'($urandom_range(0, 16))));
            queued++;
         end else begin
            nseg = $urandom_range(1, 3);
            for (int i = 0; i < nseg; i++) begin
               if (long_segs) len = tdrs_pkg::LEN_W'($urandom_range(12288, 16383));
               else if ($urandom_range(0, 3) == 0)
                  len = tdrs_pkg::LEN_W'($urandom_range(0, 16383));
               else len = tdrs_pkg::LEN_W'($urandom_range(0, 600));
               last = (i == nseg - 1);
               // now and then a broken packet with a random end flag
               if ($urandom_range(0, 9) == 0) last = 1'($urandom);
               segment_backlog.push_back(segment_req(pick_address(), len, last,
                                                     tdrs_pkg::ID_W'($urandom)));
               queued++;
            end
         end
      end
      // close any open packet so the next phase starts clean
      segment_backlog.push_back(segment_req(pick_address(), 14'd64, 1'b1,
                                            tdrs_pkg::ID_W'($urandom)));
   endtask

   task automatic write_csr(input tdrs_pkg::csr_index_type idx,
                            input logic [tdrs_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tdrs_pkg::CSR_PHYS_MODE) cfg_phys = val[0];
      else cfg_thresh = tdrs_pkg::THRESH_W'(val);
   endtask

   // wait until every request went in and every result came out, then let the block settle
   task automatic wait_quiet();
      do @(negedge clock);
      while (segment_backlog.size() != 0 || req_valid || due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            ring_producer_step(req_payload);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               gap_left  <= $urandom_range(0, 18);
            end else if (segment_backlog.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= segment_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // compare each result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_payload.kind == tdrs_pkg::KIND_REJECT) rejects_seen++;
            if (rsp_payload.kind == tdrs_pkg::KIND_DOORBELL) doorbells_seen++;
            if (rsp_payload.kind == tdrs_pkg::KIND_DOORBELL && rsp_payload.push_descriptor)
               pushes_seen++;
            if (due_results.size() == 0) begin
               $error("result with nothing predicted: kind %0d slot 0x%0h",
                      rsp_payload.kind, rsp_payload.ring_slot);
               error_count++;
            end else begin
               oldest_due = due_results.pop_front();
               compare_field("kind", 64'(oldest_due.kind), 64'(rsp_payload.kind));
               compare_field("ring_slot", 64'(oldest_due.ring_slot),
                             64'(rsp_payload.ring_slot));
               compare_field("desc_address", 64'(oldest_due.desc_address),
                             64'(rsp_payload.desc_address));
               compare_field("desc_bytes", 64'(oldest_due.desc_bytes),
                             64'(rsp_payload.desc_bytes));
               compare_field("continued", 64'(oldest_due.continued),
                             64'(rsp_payload.continued));
               compare_field("out_request_id", 64'(oldest_due.out_request_id),
                             64'(rsp_payload.out_request_id));
               compare_field("id_valid", 64'(oldest_due.id_valid),
                             64'(rsp_payload.id_valid));
               compare_field("push_descriptor", 64'(oldest_due.push_descriptor),
                             64'(rsp_payload.push_descriptor));
               compare_field("last", 64'(oldest_due.last), 64'(rsp_payload.last));
            end
         end
         // one long hold-off when asked, otherwise random stall bursts
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_req && !hold_taken) begin
            rsp_stall  <= 1'b1;
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 18);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("nothing accepted for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed, buffer mode, every single-descriptor doorbell may push
      write_csr(tdrs_pkg::CSR_PHYS_MODE, '0);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, 13'd4096);
      // empty segment at address zero
      segment_backlog.push_back(segment_req(48'h0, 14'd0, 1'b1, 16'h0000));
      // two bytes straddling a page edge
      segment_backlog.push_back(segment_req(48'h0000_0000_0fff, 14'd2, 1'b1, 16'hffff));
      // longest split, address wraps past the top
      segment_backlog.push_back(segment_req(48'hffff_ffff_f800, 14'd16383, 1'b0, 16'h1234));
      segment_backlog.push_back(segment_req(48'h0000_0000_1000, 14'd4096, 1'b1, 16'habcd));
      // completion larger than what is outstanding, then an empty one
      segment_backlog.push_back(completion_req(13'd4096));
      segment_backlog.push_back(completion_req(13'd0));
      segment_backlog.push_back(segment_req(pick_address(), 14'd1, 1'b1, 16'h0001));
      segment_backlog.push_back(segment_req(48'hffff_ffff_ffff, 14'd16383, 1'b1, 16'h7fff));
      segment_backlog.push_back(completion_req(13'd1));
      segment_backlog.push_back(segment_req(48'h0000_0000_07ff, 14'd4096, 1'b1, 16'h5555));
      wait_quiet();

      // directed, physical mode, never push
      write_csr(tdrs_pkg::CSR_PHYS_MODE, 13'd1);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, 13'd0);
      // byte count saturates
      segment_backlog.push_back(segment_req(48'hffff_ffff_ffff, 14'd16383, 1'b1, 16'hffff));
      segment_backlog.push_back(segment_req(48'h0, 14'd0, 1'b0, 16'h0001));
      segment_backlog.push_back(segment_req(48'h0000_1234_5678, 14'd8191, 1'b0, 16'h0002));
      segment_backlog.push_back(segment_req(48'h8000_0000_0000, 14'd8192, 1'b1, 16'h8000));
      segment_backlog.push_back(completion_req(13'd4096));
      wait_quiet();

      // directed, threshold of one: push only on an empty ring
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, 13'd1);
      segment_backlog.push_back(segment_req(pick_address(), 14'd100, 1'b1,
                                            tdrs_pkg::ID_W'($urandom)));
      segment_backlog.push_back(segment_req(pick_address(), 14'd5, 1'b1,
                                            tdrs_pkg::ID_W'($urandom)));
      segment_backlog.push_back(completion_req(13'd4096));
      segment_backlog.push_back(completion_req(13'd4096));
      segment_backlog.push_back(segment_req(pick_address(), 14'd16383, 1'b1, 16'h0000));
      wait_quiet();

      // random, buffer mode, ring kept light
      write_csr(tdrs_pkg::CSR_PHYS_MODE, '0);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, tdrs_pkg::CSR_DATA_W'($urandom_range(0, 12)));
      queue_packets(40, 30, 1'b0);
      wait_quiet();

      // random, physical mode
      write_csr(tdrs_pkg::CSR_PHYS_MODE, 13'd1);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, tdrs_pkg::CSR_DATA_W'($urandom_range(0, 8)));
      queue_packets(30, 30, 1'b0);
      wait_quiet();

      // random, buffer mode, long segments fill the ring while the receiver holds off
      write_csr(tdrs_pkg::CSR_PHYS_MODE, '0);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD,
                tdrs_pkg::CSR_DATA_W'($urandom_range(1, 4095)));
      hold_req <= 1'b1;
      queue_packets(110, 0, 1'b1);
      queue_packets(35, 15, 1'b1);
      wait_quiet();

      // random, physical mode, threshold above any ring occupancy, no idling
      write_csr(tdrs_pkg::CSR_PHYS_MODE, 13'd1);
      write_csr(tdrs_pkg::CSR_PUSH_THRESHOLD, 13'd4096);
      calm <= 1'b1;
      queue_packets(30, 20, 1'b0);
      wait_quiet();

      $display("%0d requests over buffer and physical modes, %0d results checked",
               requests_sent, results_seen);
      $display("%0d doorbells (%0d pushing a descriptor), %0d ring-full rejects",
               doorbells_seen, pushes_seen, rejects_seen);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tdrs_pkg.sv
hw/rtl/tdrs_chunk_unit.sv
hw/rtl/tdrs_seq.sv
hw/rtl/tx_descriptor_ring_splitter_core.sv
hw/rtl/tdrs_checker.sv
test/tb_tx_descriptor_ring_splitter_core.sv
